/* src/lph_pkg.sv */
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants for the linear-probe hash table
// Table geometry, command and status codes, request, response and slot
// layouts, and the write-port bundle of the slot memory.
// ----------------------------------------------------------------------------
package lph_pkg;

   // Table geometry
   localparam int CAPACITY = 64;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam bit IS_POW2  = ((CAPACITY & (CAPACITY - 1)) == 0);

   // Field widths
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int KEY_W    = 64;
   localparam int HASH_W   = 32;
   localparam int VALUE_W  = 32;

   // Home slot for a non power-of-two table: quotient = (hash * RECIP_M) >> shift
   // with RECIP_M = ceil(2^(HASH_W + RECIP_SH) / CAPACITY), exact for every hash
   localparam int              RECIP_SH = SLOT_W;
   localparam int              PROD_W   = 2 * HASH_W + 1;
   localparam logic [HASH_W:0] RECIP_M  =
      (HASH_W + 1)'(((longint'(1) << (HASH_W + RECIP_SH)) + longint'(CAPACITY) - 1)
                    / longint'(CAPACITY));

   // Load limit: refuse new keys once (live + tombstones) * 4 >= CAPACITY * 3
   localparam int LOAD_SHIFT = 2;
   localparam int LOAD_LIMIT = CAPACITY * 3;
   localparam int LOAD_W     = COUNT_W + 1 + LOAD_SHIFT;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [KEY_W-1:0]   key;
      logic [HASH_W-1:0]  key_hash;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [VALUE_W-1:0]  value_out;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  live_count;
   } rsp_type;

   typedef struct packed {
      logic               used;
      logic               tomb;
      logic [KEY_W-1:0]   key;
      logic [HASH_W-1:0]  hash;
      logic [VALUE_W-1:0] value;
   } slot_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      slot_type          data;
   } slot_wr_type;

endpackage

/* src/lph_slot_ram.sv */
// ----------------------------------------------------------------------------
// lph_slot_ram: slot store of the hash table
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lph_slot_ram (
   input  logic                 clock,
   input  lph_pkg::slot_wr_type wr,
   input  logic [lph_pkg::SLOT_W-1:0] rd_addr,
   output lph_pkg::slot_type    rd_data
);
   import lph_pkg::*;

   slot_type mem [CAPACITY];
   slot_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lph_seq.sv */
// ----------------------------------------------------------------------------
// lph_seq: probe sequencer of the hash table
// Clears the store after reset, reduces the hash to a home slot, walks the
// probe chain one slot per cycle through the shared key compare, then
// applies the command and updates the live and tombstone counts.
// ----------------------------------------------------------------------------
module lph_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  lph_pkg::req_type            req_data,
   output logic                        busy,
   output lph_pkg::slot_wr_type        slot_wr,
   output logic [lph_pkg::SLOT_W-1:0]  slot_rd_addr,
   input  lph_pkg::slot_type           slot_rd_data,
   output logic                        res_valid,
   output lph_pkg::rsp_type            res_data
);
   import lph_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HOME  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_APPLY = 3'd5;

   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(CAPACITY - 1);
   localparam logic [COUNT_W-1:0] PROBE_MAX = COUNT_W'(CAPACITY);
   localparam logic [HASH_W-1:0]  CAP_HASH  = HASH_W'(CAPACITY);

   logic [2:0]          state_ff, state_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;
   req_type             req_ff, req_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0]  probes_ff, probes_in;
   logic [SLOT_W-1:0]   ft_ff, ft_in;
   logic                ft_vld_ff, ft_vld_in;
   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   tgt_ff, tgt_in;
   logic                tgt_vld_ff, tgt_vld_in;
   logic                tgt_tomb_ff, tgt_tomb_in;
   logic [VALUE_W-1:0]  hit_val_ff, hit_val_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [COUNT_W-1:0]  entry_ff, entry_in;
   logic [COUNT_W-1:0]  tomb_ff, tomb_in;

   logic [HASH_W-1:0]   quot;
   logic [HASH_W-1:0]   home_rem;
   logic [SLOT_W-1:0]   idx_next;
   logic [COUNT_W-1:0]  probes_next;
   logic                key_match;
   logic                slot_empty;
   logic [SLOT_W-1:0]   ft_upd;
   logic                ft_vld_upd;
   logic [LOAD_W-1:0]   load_sum;
   logic                load_full;

   // shared compare and helpers
   assign key_match  = (slot_rd_data.hash == req_ff.key_hash) &&
                       (slot_rd_data.key == req_ff.key);
   assign slot_empty = !slot_rd_data.used && !slot_rd_data.tomb;
   assign idx_next   = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
   assign probes_next = probes_ff + 1'b1;
   assign ft_vld_upd = ft_vld_ff || slot_rd_data.tomb;
   assign ft_upd     = ft_vld_ff ? ft_ff : idx_ff;

   // hash mod CAPACITY from the registered reciprocal product
   assign quot     = HASH_W'(prod_ff >> (HASH_W + RECIP_SH));
   assign home_rem = req_ff.key_hash - quot * CAP_HASH;

   // occupancy check for new keys
   assign load_sum  = LOAD_W'({1'b0, entry_ff} + {1'b0, tomb_ff}) << LOAD_SHIFT;
   assign load_full = load_sum >= LOAD_W'(LOAD_LIMIT);

   assign busy = (state_ff != ST_IDLE);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      req_in      = req_ff;
      idx_in      = idx_ff;
      probes_in   = probes_ff;
      ft_in       = ft_ff;
      ft_vld_in   = ft_vld_ff;
      hit_in      = hit_ff;
      tgt_in      = tgt_ff;
      tgt_vld_in  = tgt_vld_ff;
      tgt_tomb_in = tgt_tomb_ff;
      hit_val_in  = hit_val_ff;
      prod_in     = prod_ff;
      entry_in    = entry_ff;
      tomb_in     = tomb_ff;
      slot_rd_addr = idx_ff;
      slot_wr.en   = 1'b0;
      slot_wr.addr = tgt_ff;
      slot_wr.data = '{used: 1'b0, tomb: 1'b0, key: req_ff.key,
                       hash: req_ff.key_hash, value: req_ff.value};
      res_valid    = 1'b0;
      res_data     = '{found: hit_ff, value_out: '0, status: STATUS_OK,
                       live_count: entry_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            slot_wr.en   = 1'b1;
            slot_wr.addr = clr_ff;
            slot_wr.data = '0;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               probes_in = '0;
               ft_vld_in = 1'b0;
               prod_in   = req_data.key_hash * RECIP_M;
               if (IS_POW2) begin
                  idx_in   = req_data.key_hash[SLOT_W-1:0];
                  state_in = ST_READ;
               end else begin
                  state_in = ST_HOME;
               end
            end
         end
         ST_HOME: begin
            idx_in   = home_rem[SLOT_W-1:0];
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // next slot is fetched while this one is judged
            slot_rd_addr = idx_next;
            ft_in        = ft_upd;
            ft_vld_in    = ft_vld_upd;
            if (slot_empty) begin
               hit_in      = 1'b0;
               tgt_in      = ft_upd;
               tgt_vld_in  = 1'b1;
               tgt_tomb_in = ft_vld_ff;
               state_in    = ST_APPLY;
            end else if (!slot_rd_data.tomb && key_match) begin
               hit_in      = 1'b1;
               hit_val_in  = slot_rd_data.value;
               tgt_in      = idx_ff;
               tgt_vld_in  = 1'b1;
               tgt_tomb_in = 1'b0;
               state_in    = ST_APPLY;
            end else if (probes_next == PROBE_MAX) begin
               // whole table walked without an empty slot
               hit_in      = 1'b0;
               tgt_in      = ft_upd;
               tgt_vld_in  = ft_vld_upd;
               tgt_tomb_in = 1'b1;
               state_in    = ST_APPLY;
            end else begin
               idx_in    = idx_next;
               probes_in = probes_next;
            end
         end
         ST_APPLY: begin
            res_valid = 1'b1;
            state_in  = ST_IDLE;
            case (req_ff.command)
               CMD_INSERT: begin
                  if (hit_ff) begin
                     slot_wr.en        = 1'b1;
                     slot_wr.data.used = 1'b1;
                  end else if (load_full || !tgt_vld_ff) begin
                     res_data.status = STATUS_FULL;
                  end else begin
                     slot_wr.en        = 1'b1;
                     slot_wr.data.used = 1'b1;
                     entry_in          = entry_ff + 1'b1;
                     if (tgt_tomb_ff) begin
                        tomb_in = tomb_ff - 1'b1;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (hit_ff) begin
                     slot_wr.en        = 1'b1;
                     slot_wr.data.tomb = 1'b1;
                     entry_in          = entry_ff - 1'b1;
                     tomb_in           = tomb_ff + 1'b1;
                  end else begin
                     res_data.status = STATUS_MISS;
                  end
               end
               default: begin
                  // lookup; the unused command code behaves the same
                  if (hit_ff) begin
                     res_data.value_out = hit_val_ff;
                  end else begin
                     res_data.status = STATUS_MISS;
                  end
               end
            endcase
            res_data.live_count = entry_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         entry_ff <= '0;
         tomb_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         entry_ff <= entry_in;
         tomb_ff  <= tomb_in;
      end
   end

   // working registers of the current item
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      probes_ff   <= probes_in;
      ft_ff       <= ft_in;
      ft_vld_ff   <= ft_vld_in;
      hit_ff      <= hit_in;
      tgt_ff      <= tgt_in;
      tgt_vld_ff  <= tgt_vld_in;
      tgt_tomb_ff <= tgt_tomb_in;
      hit_val_ff  <= hit_val_in;
      prod_ff     <= prod_in;
   end

endmodule

/* src/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table with linear probing
// Lookup, insert/update and remove of fixed-width keys; tombstones mark
// removed slots and are reused by later inserts.
// ----------------------------------------------------------------------------
// A request beat is taken at a clock edge with start high and busy low. The
// response beat is on rsp_data for exactly one cycle, marked by rsp_valid,
// and cannot be held off by the receiver. After reset the block runs a
// clearing pass over all CAPACITY slots with busy high. An item visiting P
// slots keeps busy high through a read setup state, ST_READ, then ST_CHECK,
// where one slot is read from the slot memory's read port and compared per
// cycle, then an update state, ST_APPLY; its registered response appears
// in the cycle busy falls, and a new request can be taken in the same cycle
// the response is shown. When CAPACITY is not a power of two, the state
// ST_HOME finds the home slot first: a reciprocal multiply on the accept
// edge, then a subtract of the quotient times CAPACITY.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lph_pkg::req_type req_data,
   output logic             rsp_valid,
   output lph_pkg::rsp_type rsp_data
);
   import lph_pkg::*;

   slot_wr_type         slot_wr;
   logic [SLOT_W-1:0]   slot_rd_addr;
   slot_type            slot_rd_data;
   logic                res_valid;
   rsp_type             res_data;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   lph_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_data     (req_data),
      .busy         (busy),
      .slot_wr      (slot_wr),
      .slot_rd_addr (slot_rd_addr),
      .slot_rd_data (slot_rd_data),
      .res_valid    (res_valid),
      .res_data     (res_data)
   );

   lph_slot_ram u_slot_ram (
      .clock   (clock),
      .wr      (slot_wr),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   // response beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
